// ----- sv/tccru_pkg.sv -----
// Package for the touch coordinate calibrate/rotate unit.
// Holds widths, calibration constants, register indexes and the config struct.
// No dependencies.
package tccru_pkg;

    localparam int RAW_W    = 12;
    localparam int COORD_W  = 10;
    localparam int CALC_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam int DIV_SHIFT = 22;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_TYPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd3;

    // panel calibration sets; code 3 aliases set 0
    localparam logic [1:0] PANEL_SET0  = 2'd0;
    localparam logic [1:0] PANEL_SET1  = 2'd1;
    localparam logic [1:0] PANEL_SET2  = 2'd2;
    localparam logic [1:0] PANEL_ALIAS = 2'd3;

    localparam logic [1:0] ROT_SWAP_A = 2'd0;
    localparam logic [1:0] ROT_FLIP   = 2'd1;
    localparam logic [1:0] ROT_SWAP_B = 2'd2;
    localparam logic [1:0] ROT_NONE   = 2'd3;

    // reset values
    localparam logic [1:0]         RST_PANEL_TYPE    = PANEL_SET2;
    localparam logic [1:0]         RST_ROTATION      = ROT_SWAP_A;
    localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 10'd240;
    localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 10'd320;

    // calibration offsets and divisors
    localparam logic signed [CALC_W-1:0] OFS_A = 16'sd192;
    localparam logic signed [CALC_W-1:0] OFS_X = 16'sd300;
    localparam logic signed [CALC_W-1:0] OFS_Y = 16'sd270;
    localparam logic signed [CALC_W-1:0] SET2_Y_BASE = CALC_W'(340 * 21 + 2 * 270);
    localparam logic signed [CALC_W-1:0] ROT_W = 16'sd240;
    localparam logic signed [CALC_W-1:0] ROT_H = 16'sd320;

    localparam int unsigned DIV_X  = 14;
    localparam int unsigned DIV_Y  = 21;
    localparam int unsigned DIV_A_X = 76;
    localparam int unsigned DIV_A_Y = 57;

    typedef struct packed {
        logic [1:0]         panel_type;
        logic [1:0]         rotation;
        logic [COORD_W-1:0] screen_width;
        logic [COORD_W-1:0] screen_height;
    } cfg_t;

endpackage

// ----- sv/tccru_divc.sv -----
// Signed division by a positive constant, truncating toward zero.
// Reciprocal multiply on the magnitude; uses tccru_pkg.
module tccru_divc #(
    parameter int unsigned DIVISOR = tccru_pkg::DIV_X
) (
    input  logic signed [tccru_pkg::CALC_W-1:0] num_i,
    output logic signed [tccru_pkg::CALC_W-1:0] quot_o
);
    localparam int W  = tccru_pkg::CALC_W;
    localparam int SH = tccru_pkg::DIV_SHIFT;
    // ceil(2^SH / DIVISOR); exact for magnitudes below 2^SH / DIVISOR
    localparam logic [SH:0] RECIP = (SH+1)'((2**SH + DIVISOR - 1) / DIVISOR);

    logic [W-1:0]    mag;
    logic [W+SH:0]   prod;
    logic [W-1:0]    quot_mag;

    assign mag      = num_i[W-1] ? W'(-num_i) : W'(num_i);
    assign prod     = (W+SH+1)'(mag) * (W+SH+1)'(RECIP);
    assign quot_mag = prod[SH +: W];
    assign quot_o   = num_i[W-1] ? -signed'(quot_mag) : signed'(quot_mag);

endmodule

// ----- sv/tccru_xform.sv -----
// Calibration, rotation and clamp datapath (combinational).
// Uses tccru_pkg and tccru_divc.
module tccru_xform (
    input  tccru_pkg::cfg_t                     cfg_i,
    input  logic [tccru_pkg::RAW_W-1:0]         raw_x_i,
    input  logic [tccru_pkg::RAW_W-1:0]         raw_y_i,
    output logic [tccru_pkg::COORD_W-1:0]       screen_x_o,
    output logic [tccru_pkg::COORD_W-1:0]       screen_y_o
);
    localparam int W  = tccru_pkg::CALC_W;
    localparam int CW = tccru_pkg::COORD_W;

    logic signed [W-1:0] rx, ry;
    logic signed [W-1:0] dx_a, dy_a, dx, dy;
    logic signed [W-1:0] num_x0, num_y0, num_x12, num_y1, num_y2;
    logic signed [W-1:0] q_x0, q_y0, q_x12, q_y1, q_y2;
    logic signed [W-1:0] cal_x, cal_y, rot_x, rot_y;

    function automatic logic [CW-1:0] clamp(input logic signed [W-1:0] v,
                                            input logic [CW-1:0] limit);
        logic [CW-1:0] res;
        if (v[W-1]) begin
            res = '0;
        end else if (v[W-2:0] > (W-1)'(limit)) begin
            res = limit;
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    assign rx = signed'(W'(raw_x_i));
    assign ry = signed'(W'(raw_y_i));

    assign dx_a    = rx - tccru_pkg::OFS_A;
    assign dy_a    = ry - tccru_pkg::OFS_A;
    assign dx      = rx - tccru_pkg::OFS_X;
    assign dy      = ry - tccru_pkg::OFS_Y;
    assign num_x0  = (dy_a <<< 2) + dy_a;
    assign num_y0  = (dx_a <<< 2) + dx_a;
    assign num_x12 = dx;
    assign num_y1  = dy + dy;
    assign num_y2  = tccru_pkg::SET2_Y_BASE - (ry + ry);

    tccru_divc #(.DIVISOR(tccru_pkg::DIV_A_X)) u_div_x0 (.num_i(num_x0), .quot_o(q_x0));
    tccru_divc #(.DIVISOR(tccru_pkg::DIV_A_Y)) u_div_y0 (.num_i(num_y0), .quot_o(q_y0));
    tccru_divc #(.DIVISOR(tccru_pkg::DIV_X)) u_div_x12 (.num_i(num_x12), .quot_o(q_x12));
    tccru_divc #(.DIVISOR(tccru_pkg::DIV_Y)) u_div_y1 (.num_i(num_y1), .quot_o(q_y1));
    tccru_divc #(.DIVISOR(tccru_pkg::DIV_Y)) u_div_y2 (.num_i(num_y2), .quot_o(q_y2));

    always_comb begin
        case (cfg_i.panel_type)
            tccru_pkg::PANEL_SET1: begin
                cal_x = tccru_pkg::ROT_W - q_x12;
                cal_y = q_y1;
            end
            tccru_pkg::PANEL_SET2: begin
                cal_x = q_x12;
                cal_y = q_y2;
            end
            default: begin
                cal_x = q_x0;
                cal_y = q_y0;
            end
        endcase
    end

    always_comb begin
        case (cfg_i.rotation)
            tccru_pkg::ROT_SWAP_A: begin
                rot_x = cal_y;
                rot_y = tccru_pkg::ROT_W - cal_x;
            end
            tccru_pkg::ROT_FLIP: begin
                rot_x = tccru_pkg::ROT_W - cal_x;
                rot_y = tccru_pkg::ROT_H - cal_y;
            end
            tccru_pkg::ROT_SWAP_B: begin
                rot_x = tccru_pkg::ROT_H - cal_y;
                rot_y = cal_x;
            end
            default: begin
                rot_x = cal_x;
                rot_y = cal_y;
            end
        endcase
    end

    assign screen_x_o = clamp(rot_x, cfg_i.screen_width);
    assign screen_y_o = clamp(rot_y, cfg_i.screen_height);

endmodule

// ----- sv/touch_coordinate_calibrate_rotate_unit.sv -----
// Touch coordinate calibrate/rotate unit, top level.
// Pipeline: input register, then result register, with the constant dividers and muxes in
// one stage between them; m_tvalid rises when a transaction reaches the result register.
// Throughput: one transaction per cycle while m_tready does not stall the result register.
// Reset (aresetn, synchronous): both stages empty, panel_type 2, rotation 0,
// screen_width 240, screen_height 320.
// Uses tccru_pkg and tccru_xform.
module touch_coordinate_calibrate_rotate_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tccru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tccru_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // raw_x[11:0], raw_y[23:12]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata   // screen_x[9:0], screen_y[19:10], 0
);
    localparam int RW = tccru_pkg::RAW_W;
    localparam int CW = tccru_pkg::COORD_W;

    tccru_pkg::cfg_t cfg_reg;
    logic            in_valid_reg, out_valid_reg;
    logic [RW-1:0]   raw_x_reg, raw_y_reg;
    logic [CW-1:0]   sx_reg, sy_reg;
    logic [CW-1:0]   sx_next, sy_next;
    logic            advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, sy_reg, sx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_type    <= tccru_pkg::RST_PANEL_TYPE;
            cfg_reg.rotation      <= tccru_pkg::RST_ROTATION;
            cfg_reg.screen_width  <= tccru_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= tccru_pkg::RST_SCREEN_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tccru_pkg::CFG_PANEL_TYPE:    cfg_reg.panel_type    <= cfg_wdata[1:0];
                tccru_pkg::CFG_ROTATION:      cfg_reg.rotation      <= cfg_wdata[1:0];
                tccru_pkg::CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_wdata[CW-1:0];
                tccru_pkg::CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_wdata[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            raw_x_reg <= s_tdata[RW-1:0];
            raw_y_reg <= s_tdata[2*RW-1:RW];
        end
        if (advance && in_valid_reg) begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    tccru_xform u_xform (
        .cfg_i      (cfg_reg),
        .raw_x_i    (raw_x_reg),
        .raw_y_i    (raw_y_reg),
        .screen_x_o (sx_next),
        .screen_y_o (sy_next)
    );

endmodule

// ----- bench/touch_coordinate_calibrate_rotate_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench for touch_coordinate_calibrate_rotate_unit: drives touch sample pairs under
// random idling and backpressure and checks every coordinate pair against a local predictor.
// Depends on tccru_pkg and the unit's RTL.
module touch_coordinate_calibrate_rotate_unit_test;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_LEN    = 300;

    typedef struct packed {
        logic [tccru_pkg::COORD_W-1:0] screen_y;
        logic [tccru_pkg::COORD_W-1:0] screen_x;
    } screen_pt_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [tccru_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tccru_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [23:0]                      s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [23:0]                      m_tdata;

    tccru_pkg::cfg_t model_cfg;
    screen_pt_t      expected_pts[$];
    int              failures      = 0;
    int              cycle_count   = 0;
    bit              tx_idle_en    = 1'b1;
    bit              rx_stall_en   = 1'b1;
    int              hold_requests = 0;
    int              holds_served  = 0;
    int              hold_left     = 0;
    int              stall_left    = 0;

    touch_coordinate_calibrate_rotate_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("touch_coordinate_calibrate_rotate_unit_test failed");
            $finish;
        end
    end

    function automatic logic [tccru_pkg::COORD_W-1:0] clamp_to(
        int v, logic [tccru_pkg::COORD_W-1:0] lim);
        if (v < 0)
            return '0;
        if (v > int'(lim))
            return lim;
        return v[tccru_pkg::COORD_W-1:0];
    endfunction

    function automatic screen_pt_t calc_screen(logic [tccru_pkg::RAW_W-1:0] rx,
                                               logic [tccru_pkg::RAW_W-1:0] ry,
                                               tccru_pkg::cfg_t c);
        int         vx;
        int         vy;
        int         x;
        int         y;
        int         t;
        logic [1:0] cal_set;
        screen_pt_t pt;
        vx = int'(rx);
        vy = int'(ry);
        cal_set = (c.panel_type == tccru_pkg::PANEL_ALIAS) ? tccru_pkg::PANEL_SET0
                                                           : c.panel_type;
        case (cal_set)
            tccru_pkg::PANEL_SET0: begin
                x = (5 * (vy - 192)) / 76;
                y = (5 * (vx - 192)) / 57;
            end
            tccru_pkg::PANEL_SET1: begin
                x = 240 - (vx - 300) / 14;
                y = (2 * (vy - 270)) / 21;
            end
            default: begin
                x = (vx - 300) / 14;
                y = (340 * 21 - 2 * (vy - 270)) / 21;
            end
        endcase
        t = x;
        case (c.rotation)
            tccru_pkg::ROT_SWAP_A: begin
                x = y;
                y = 240 - t;
            end
            tccru_pkg::ROT_FLIP: begin
                x = 240 - x;
                y = 320 - y;
            end
            tccru_pkg::ROT_SWAP_B: begin
                x = 320 - y;
                y = t;
            end
            default: ;
        endcase
        pt.screen_x = clamp_to(x, c.screen_width);
        pt.screen_y = clamp_to(y, c.screen_height);
        return pt;
    endfunction

    function automatic logic [tccru_pkg::RAW_W-1:0] rand_raw();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        return tccru_pkg::RAW_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [tccru_pkg::COORD_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 10'd1023;
            2: return 10'd240;
            3: return 10'd320;
            default: return tccru_pkg::COORD_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // result side: random stalls per transaction, plus long holds on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_LEN;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end else if (m_tvalid && m_tready) begin
            int w;
            w = rx_stall_en ? $urandom_range(0, 15) : 0;
            stall_left <= w;
            m_tready   <= (w == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // output check before input capture, so ordering within the edge is fixed
    always @(posedge aclk) begin : check_results
        screen_pt_t exp_pt;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_pts.size() == 0) begin
                    $error("unexpected result transaction: m_tdata %h", m_tdata);
                    failures++;
                end else begin
                    exp_pt = expected_pts.pop_front();
                    if (m_tdata[9:0] !== exp_pt.screen_x) begin
                        $error("screen_x mismatch: expected %0d, actual %0d",
                               exp_pt.screen_x, m_tdata[9:0]);
                        failures++;
                    end
                    if (m_tdata[19:10] !== exp_pt.screen_y) begin
                        $error("screen_y mismatch: expected %0d, actual %0d",
                               exp_pt.screen_y, m_tdata[19:10]);
                        failures++;
                    end
                    if (m_tdata[23:20] !== 4'h0) begin
                        $error("tdata pad mismatch: expected %0d, actual %0d",
                               4'h0, m_tdata[23:20]);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_pts.push_back(calc_screen(s_tdata[11:0], s_tdata[23:12], model_cfg));
        end
    end

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_sample(logic [tccru_pkg::RAW_W-1:0] rx,
                               logic [tccru_pkg::RAW_W-1:0] ry);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ry, rx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // waits on a clock edge before polling, so the last accepted transaction is already queued
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_pts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // panel_type and rotation get random upper bits, which the unit must ignore
    task automatic set_config(logic [1:0] panel, logic [1:0] rot,
                              logic [tccru_pkg::COORD_W-1:0] w,
                              logic [tccru_pkg::COORD_W-1:0] h);
        logic [tccru_pkg::CFG_DATA_W-1:0] vals [4];
        logic [tccru_pkg::CFG_IDX_W-1:0]  idx;
        vals[tccru_pkg::CFG_PANEL_TYPE]    = {8'($urandom), panel};
        vals[tccru_pkg::CFG_ROTATION]      = {8'($urandom), rot};
        vals[tccru_pkg::CFG_SCREEN_WIDTH]  = w;
        vals[tccru_pkg::CFG_SCREEN_HEIGHT] = h;
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            idx = tccru_pkg::CFG_IDX_W'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= vals[i];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            case (idx)
                tccru_pkg::CFG_PANEL_TYPE:    model_cfg.panel_type    = vals[i][1:0];
                tccru_pkg::CFG_ROTATION:      model_cfg.rotation      = vals[i][1:0];
                tccru_pkg::CFG_SCREEN_WIDTH:  model_cfg.screen_width  = vals[i];
                tccru_pkg::CFG_SCREEN_HEIGHT: model_cfg.screen_height = vals[i];
                default: ;
            endcase
            @(posedge aclk);
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(12'h000, 12'h000);
        send_sample(12'hFFF, 12'hFFF);
        send_sample(12'h000, 12'hFFF);
        send_sample(12'd300, 12'd270);
    endtask

    // every panel code (alias included) against every rotation, corner samples
    task automatic test_panel_rotation_grid();
        logic [tccru_pkg::RAW_W-1:0] cx [4] = '{12'h000, 12'hFFF, 12'h000, 12'hFFF};
        logic [tccru_pkg::RAW_W-1:0] cy [4] = '{12'h000, 12'hFFF, 12'hFFF, 12'h000};
        for (int p = 0; p < 4; p++) begin
            for (int r = 0; r < 4; r++) begin
                set_config(2'(p), 2'(r), 10'd1023, 10'd1023);
                send_sample(cx[(p + r) % 4], cy[(p + r) % 4]);
            end
        end
    endtask

    task automatic test_clamp_limits();
        set_config(tccru_pkg::PANEL_SET2, tccru_pkg::ROT_NONE, 10'd0, 10'd0);
        send_sample(12'hFFF, 12'h000);
        set_config(tccru_pkg::PANEL_SET2, tccru_pkg::ROT_NONE, 10'd1, 10'd1);
        send_sample(12'hFFF, 12'h000);
        set_config(tccru_pkg::PANEL_SET1, tccru_pkg::ROT_FLIP, 10'd1023, 10'd1023);
        send_sample(12'h000, 12'hFFF);
    endtask

    task automatic test_random_configs();
        for (int ph = 0; ph < 12; ph++) begin
            set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       pick_limit(), pick_limit());
            tx_idle_en  = (ph % 4 != 1);
            rx_stall_en = (ph % 4 != 2);
            for (int n = 0; n < 125; n++)
                send_sample(rand_raw(), rand_raw());
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    task automatic test_backpressure();
        set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   pick_limit(), pick_limit());
        tx_idle_en = 1'b0;
        hold_requests <= hold_requests + 1;
        for (int n = 0; n < 40; n++)
            send_sample(rand_raw(), rand_raw());
        wait_drained();
        tx_idle_en = 1'b1;
        for (int n = 0; n < 40; n++)
            send_sample(rand_raw(), rand_raw());
    endtask

    initial begin
        model_cfg.panel_type    = tccru_pkg::RST_PANEL_TYPE;
        model_cfg.rotation      = tccru_pkg::RST_ROTATION;
        model_cfg.screen_width  = tccru_pkg::RST_SCREEN_WIDTH;
        model_cfg.screen_height = tccru_pkg::RST_SCREEN_HEIGHT;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_panel_rotation_grid();
        test_clamp_limits();
        test_random_configs();
        test_backpressure();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (failures == 0)
            $display("touch_coordinate_calibrate_rotate_unit_test passed");
        else
            $display("touch_coordinate_calibrate_rotate_unit_test failed");
        $finish;
    end

endmodule

// ----- touch_coordinate_calibrate_rotate_unit.f -----
sv/tccru_pkg.sv
sv/tccru_divc.sv
sv/tccru_xform.sv
sv/touch_coordinate_calibrate_rotate_unit.sv
bench/touch_coordinate_calibrate_rotate_unit_test.sv
